[rtl/skp_pkg.sv]
package skp_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int MAG_W     = 64;  // magnitude of a wrapped 64-bit difference
	localparam int DEN_W     = 76;  // 3600 * |det| fits in 76 bits
	localparam int QUO_W     = 42;  // quotient carries one extra bit for rounding
	localparam int LOW_W     = 5;   // numerator bits shifted into the divider
	localparam int DIV_STAGES = 21; // two quotient bits per stage

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CD_11 = 3'd0,
		REG_CD_12 = 3'd1,
		REG_CD_21 = 3'd2,
		REG_CD_22 = 3'd3,
		REG_REF_X = 3'd4,
		REG_REF_Y = 3'd5
	} skp_reg_t;

	// one item inside the divider pipeline
	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem_x;
		logic [DEN_W-1:0] rem_y;
		logic [QUO_W-1:0] quo_x;
		logic [QUO_W-1:0] quo_y;
		logic [LOW_W-1:0] low_x;
		logic [LOW_W-1:0] low_y;
		logic             neg_x;
		logic             neg_y;
		logic             ovf_x;
		logic             ovf_y;
		logic             singular;
		logic             last;
	} skp_div_t;

	// one restoring step: shift in a dividend bit, subtract when it fits
	function automatic void div_step(input logic [DEN_W-1:0] rem, input logic [DEN_W-1:0] den,
		input logic inbit, output logic [DEN_W-1:0] rem_n, output logic qbit);
		logic [DEN_W:0] r;
		r = {rem, inbit};
		if (r >= {1'b0, den}) begin
			rem_n = DEN_W'(r - {1'b0, den});
			qbit  = 1'b1;
		end else begin
			rem_n = r[DEN_W-1:0];
			qbit  = 1'b0;
		end
	endfunction

endpackage

[rtl/skp_front.sv]
module skp_front import skp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] offset_ra,
	input  logic signed [31:0] offset_dec,
	input  logic               last_in,
	input  logic signed [31:0] cd_11,
	input  logic signed [31:0] cd_12,
	input  logic signed [31:0] cd_21,
	input  logic signed [31:0] cd_22,
	output logic               out_valid,
	input  logic               out_ready,
	output skp_div_t           out_data
);

	logic signed [63:0] p_d1_s1, p_d2_s1, p_x1_s1, p_x2_s1, p_y1_s1, p_y2_s1;
	logic               last_s1, v_s1, rdy1;
	logic [MAG_W-1:0]   dmag_s2, nx_s2, ny_s2;
	logic               negx_s2, negy_s2, sing_s2, last_s2, v_s2, rdy2;
	logic               v_s3, rdy3;
	skp_div_t           dat_s3;

	logic [63:0]        det_w, nx_w, ny_w;
	logic [DEN_W-1:0]   den_w, remx_w, remy_w;
	logic               ovfx_w, ovfy_w;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		// differences wrap at 64 bits
		det_w = 64'(p_d1_s1 - p_d2_s1);
		nx_w  = 64'(p_x1_s1 - p_x2_s1);
		ny_w  = 64'(p_y1_s1 - p_y2_s1);
	end

	always_comb begin
		// 3600 = 4096 - 512 + 16
		den_w  = (DEN_W'(dmag_s2) << 12) - (DEN_W'(dmag_s2) << 9) + (DEN_W'(dmag_s2) << 4);
		remx_w = DEN_W'(nx_s2[MAG_W-1:LOW_W]);
		remy_w = DEN_W'(ny_s2[MAG_W-1:LOW_W]);
		// quotient would reach 2^41 or more
		ovfx_w = remx_w >= den_w;
		ovfy_w = remy_w >= den_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			p_d1_s1 <= cd_11 * cd_22;
			p_d2_s1 <= cd_12 * cd_21;
			p_x1_s1 <= offset_ra * cd_22;
			p_x2_s1 <= offset_dec * cd_12;
			p_y1_s1 <= offset_dec * cd_11;
			p_y2_s1 <= offset_ra * cd_21;
			last_s1 <= last_in;
		end
		if (rdy2) begin
			dmag_s2 <= det_w[63] ? 64'(-det_w) : det_w;
			nx_s2   <= nx_w[63] ? 64'(-nx_w) : nx_w;
			ny_s2   <= ny_w[63] ? 64'(-ny_w) : ny_w;
			negx_s2 <= nx_w[63] ^ det_w[63];
			negy_s2 <= ny_w[63] ^ det_w[63];
			sing_s2 <= det_w == 64'd0;
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			dat_s3.den      <= den_w;
			dat_s3.rem_x    <= ovfx_w ? '0 : remx_w;
			dat_s3.rem_y    <= ovfy_w ? '0 : remy_w;
			dat_s3.quo_x    <= '0;
			dat_s3.quo_y    <= '0;
			dat_s3.low_x    <= nx_s2[LOW_W-1:0];
			dat_s3.low_y    <= ny_s2[LOW_W-1:0];
			dat_s3.neg_x    <= negx_s2;
			dat_s3.neg_y    <= negy_s2;
			dat_s3.ovf_x    <= ovfx_w;
			dat_s3.ovf_y    <= ovfy_w;
			dat_s3.singular <= sing_s2;
			dat_s3.last     <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = dat_s3;

endmodule

[rtl/skp_div_stage.sv]
module skp_div_stage import skp_pkg::*; #(
	parameter int BIT_HI = 41
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  skp_div_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output skp_div_t out_data
);

	localparam int BIT_LO = BIT_HI - 1;

	logic     v_s1;
	skp_div_t dat_s1, nxt;
	logic [DEN_W-1:0] rx_a, ry_a;
	logic qx_a, qy_a, qx_b, qy_b, ibx_a, iby_a, ibx_b, iby_b;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		// dividend bits below the numerator's low five are zero
		ibx_a = (BIT_HI >= 37) ? in_data.low_x[3'(BIT_HI - 37)] : 1'b0;
		iby_a = (BIT_HI >= 37) ? in_data.low_y[3'(BIT_HI - 37)] : 1'b0;
		ibx_b = (BIT_LO >= 37) ? in_data.low_x[3'(BIT_LO - 37)] : 1'b0;
		iby_b = (BIT_LO >= 37) ? in_data.low_y[3'(BIT_LO - 37)] : 1'b0;
		nxt = in_data;
		div_step(in_data.rem_x, in_data.den, ibx_a, rx_a, qx_a);
		div_step(in_data.rem_y, in_data.den, iby_a, ry_a, qy_a);
		div_step(rx_a, in_data.den, ibx_b, nxt.rem_x, qx_b);
		div_step(ry_a, in_data.den, iby_b, nxt.rem_y, qy_b);
		nxt.quo_x = {in_data.quo_x[QUO_W-3:0], qx_a, qx_b};
		nxt.quo_y = {in_data.quo_y[QUO_W-3:0], qy_a, qy_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) dat_s1 <= nxt;
	end

	assign out_valid = v_s1;
	assign out_data  = dat_s1;

endmodule

[rtl/skp_out.sv]
module skp_out import skp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  skp_div_t           in_data,
	input  logic signed [31:0] ref_pixel_x,
	input  logic signed [31:0] ref_pixel_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        pixel_x,
	output logic [31:0]        pixel_y,
	output logic               singular,
	output logic               saturated,
	output logic               last_out
);

	localparam logic [QUO_W-1:0] QCAP = QUO_W'(1) << (QUO_W - 1);

	logic        v_s1;
	logic [31:0] px_w, py_w;
	logic        satx_w, saty_w;

	function automatic logic [32:0] axis(input logic [QUO_W-1:0] quo, input logic ovf,
		input logic neg, input logic signed [31:0] refp);
		logic [QUO_W-1:0]   q;
		logic signed [43:0] delta, sum;
		logic               sat;
		logic [31:0]        res;
		// round half up on the extra quotient bit, cap at 2^41
		q     = ovf ? QCAP : ({1'b0, quo[QUO_W-1:1]} + QUO_W'(quo[0]));
		delta = neg ? -$signed(44'(q)) : $signed(44'(q));
		sum   = 44'(refp) + delta;
		sat   = 1'b0;
		res   = sum[31:0];
		if (sum > 44'sd2147483647) begin
			res = 32'h7fff_ffff;
			sat = 1'b1;
		end else if (sum < -44'sd2147483648) begin
			res = 32'h8000_0000;
			sat = 1'b1;
		end
		return {sat, res};
	endfunction

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		{satx_w, px_w} = axis(in_data.quo_x, in_data.ovf_x, in_data.neg_x, ref_pixel_x);
		{saty_w, py_w} = axis(in_data.quo_y, in_data.ovf_y, in_data.neg_y, ref_pixel_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			pixel_x   <= in_data.singular ? 32'd0 : px_w;
			pixel_y   <= in_data.singular ? 32'd0 : py_w;
			singular  <= in_data.singular;
			saturated <= !in_data.singular && (satx_w || saty_w);
			last_out  <= in_data.last;
		end
	end

	assign out_valid = v_s1;

endmodule

[rtl/sky_offset_to_pixel_transform.sv]
// channel | dir | tdata (low bit up)           | tuser (low bit up)   | tlast
// s_      | in  | offset_ra, offset_dec        | -                    | last_in
// m_      | out | pixel_x, pixel_y             | singular, saturated  | last_out
// cfg_    | in  | write: cfg_we, cfg_index, cfg_wdata
// One item per cycle while m_tready is high; 3 front stages (products,
// determinant and numerators, 3600 scaling), 21 divider stages at two
// quotient bits each, one rounding/saturation stage.
// Each stage holds its own valid bit and advances when the next one is free,
// so bubbles close up under a stall. Reset clears the valid bits and the
// configuration registers; datapath registers are not reset.
module sky_offset_to_pixel_transform import skp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // offset_ra, offset_dec
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,   // pixel_x, pixel_y
	output logic [1:0]           m_tuser,   // singular, saturated
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata
);

	logic signed [31:0] cd11_q, cd12_q, cd21_q, cd22_q, refx_q, refy_q;
	logic               vld [0:DIV_STAGES];
	logic               rdy [0:DIV_STAGES];
	skp_div_t           dat [0:DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd11_q <= '0;
			cd12_q <= '0;
			cd21_q <= '0;
			cd22_q <= '0;
			refx_q <= '0;
			refy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CD_11: cd11_q <= cfg_wdata;
				REG_CD_12: cd12_q <= cfg_wdata;
				REG_CD_21: cd21_q <= cfg_wdata;
				REG_CD_22: cd22_q <= cfg_wdata;
				REG_REF_X: refx_q <= cfg_wdata;
				REG_REF_Y: refy_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	skp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.offset_ra(s_tdata[31:0]), .offset_dec(s_tdata[63:32]), .last_in(s_tlast),
		.cd_11(cd11_q), .cd_12(cd12_q), .cd_21(cd21_q), .cd_22(cd22_q),
		.out_valid(vld[0]), .out_ready(rdy[0]), .out_data(dat[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		skp_div_stage #(.BIT_HI(QUO_W - 1 - 2 * k)) u_stage (
			.clk(clk), .arst_n(arst_n),
			.in_valid(vld[k]), .in_ready(rdy[k]), .in_data(dat[k]),
			.out_valid(vld[k+1]), .out_ready(rdy[k+1]), .out_data(dat[k+1])
		);
	end

	skp_out u_out (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld[DIV_STAGES]), .in_ready(rdy[DIV_STAGES]), .in_data(dat[DIV_STAGES]),
		.ref_pixel_x(refx_q), .ref_pixel_y(refy_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.pixel_x(m_tdata[31:0]), .pixel_y(m_tdata[63:32]),
		.singular(m_tuser[0]), .saturated(m_tuser[1]), .last_out(m_tlast)
	);

endmodule

[tb/sv/sky_offset_to_pixel_transform_test.sv]
module sky_offset_to_pixel_transform_test import skp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
	localparam logic [63:0] QUOT_CAP = 64'd1 << 41;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic        singular;
		logic        saturated;
		logic        last;
	} pixel_t;

	typedef struct {
		int          cfg_set;  // -1: registers as after reset
		logic [31:0] ra;
		logic [31:0] dec;
		logic        last;
		bit          typed;
		pixel_t      exp_pix;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;

	logic signed [31:0] cd_reg[4];
	logic signed [31:0] ref_x, ref_y;
	pixel_t pending_pix[$];
	pixel_t typed_pix[$];
	bit typed_flag[$];
	int errors = 0;
	int gap_max = 9;

	sky_offset_to_pixel_transform dut (.*);

	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// rounded |n| * 2^36 / (3600 * |d|), signed, added to ref and clipped
	function automatic logic [31:0] axis_pixel(input logic signed [31:0] refp,
		input longint n, input longint d, inout logic sat);
		logic [63:0] mn, md, q;
		logic [127:0] a, b, qw, r;
		longint delta, s;
		mn = n < 0 ? 64'(-n) : 64'(n);
		md = d < 0 ? 64'(-d) : 64'(d);
		a = {28'd0, mn, 36'd0};
		b = 128'(md) * 128'd3600;
		qw = a / b;
		r = a % b;
		if (qw >= 128'(QUOT_CAP)) q = QUOT_CAP;
		else begin
			q = qw[63:0];
			if ((r << 1) >= b) q = q + 1;
			if (q > QUOT_CAP) q = QUOT_CAP;
		end
		delta = ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
		s = longint'(refp) + delta;
		if (s > 64'sd2147483647) begin
			s = 64'sd2147483647;
			sat = 1'b1;
		end
		if (s < -64'sd2147483648) begin
			s = -64'sd2147483648;
			sat = 1'b1;
		end
		return s[31:0];
	endfunction

	function automatic pixel_t sky_to_pixel(input logic [31:0] ra, input logic [31:0] dec,
		input logic last);
		pixel_t p;
		longint ora, odec, det;
		logic sat;
		ora = longint'(signed'(ra));
		odec = longint'(signed'(dec));
		det = longint'(cd_reg[0]) * longint'(cd_reg[3]) - longint'(cd_reg[1]) * longint'(cd_reg[2]);
		p = '0;
		p.last = last;
		sat = 1'b0;
		if (det == 0) begin
			p.singular = 1'b1;
			return p;
		end
		p.px = axis_pixel(ref_x, ora * longint'(cd_reg[3]) - odec * longint'(cd_reg[1]), det, sat);
		p.py = axis_pixel(ref_y, odec * longint'(cd_reg[0]) - ora * longint'(cd_reg[2]), det, sat);
		p.saturated = sat;
		return p;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(0, 2000)) - 1000);
			3: return $urandom;
			default: return 32'(int'($urandom_range(0, 32'h01000000)) - 32'h00800000);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_CD_11: cd_reg[0] = val;
			REG_CD_12: cd_reg[1] = val;
			REG_CD_21: cd_reg[2] = val;
			REG_CD_22: cd_reg[3] = val;
			REG_REF_X: ref_x = val;
			REG_REF_Y: ref_y = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// one register set per phase; block must be idle
	task automatic load_config(input int k);
		logic [31:0] v[6];
		int scale;
		wait_drained();
		case (k)
			0: v = '{32'sd300000000, 32'sd0, 32'sd0, 32'sd300000000, 32'sd4096000, -32'sd4096000};
			1: v = '{32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0};  // tiny det: large offsets saturate
			2: v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
				32'h7fffffff, 32'h80000000};
			3: v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
				32'h80000000, 32'h7fffffff};
			4: v = '{32'sd2, 32'sd6, 32'sd1, 32'sd3, 32'sd12345, 32'sd777};  // det zero
			5: v = '{-32'sd250000000, 32'sd90000000, 32'sd80000000, 32'sd260000000,
				32'sd1000, 32'sd2000};
			default: begin
				scale = $urandom_range(0, 2);
				foreach (v[i]) begin
					v[i] = (scale == 0) ? rand_word() :
						32'(int'($urandom_range(0, 600000000)) - 300000000);
				end
			end
		endcase
		for (int i = 0; i < 6; i++) write_reg(CFG_IDX_W'(i), v[i]);
		if ($urandom_range(0, 1)) write_reg(REG_SPARE, $urandom);  // ignored index
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_offset(input logic [31:0] ra, input logic [31:0] dec,
		input logic last);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dec, ra};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// expectation is queued at the accepting edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (typed_flag.size() != 0 && typed_flag.pop_front()) begin
				pending_pix.push_back(typed_pix.pop_front());
			end else begin
				pending_pix.push_back(sky_to_pixel(s_tdata[31:0], s_tdata[63:32], s_tlast));
			end
		end
	end

	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pix.size() == 0) begin
				$error("unexpected item: tdata %h tuser %b", m_tdata, m_tuser);
				errors++;
			end else begin
				e = pending_pix.pop_front();
				if (m_tdata[31:0] !== e.px) begin
					$error("pixel_x expected %h actual %h", e.px, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.py) begin
					$error("pixel_y expected %h actual %h", e.py, m_tdata[63:32]);
					errors++;
				end
				if (m_tuser[0] !== e.singular) begin
					$error("singular expected %b actual %b", e.singular, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.saturated) begin
					$error("saturated expected %b actual %b", e.saturated, m_tuser[1]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_out expected %b actual %b", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, gap_max);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		stim_row_t rows[$];
		pixel_t sing, sing_l;
		int cur_set;
		logic [31:0] ra, dec;
		sing = '0;
		sing.singular = 1'b1;
		sing_l = sing;
		sing_l.last = 1'b1;
		rows = '{
			'{-1, 32'h7fffffff, 32'h80000000, 1'b1, 1'b1, sing_l},
			'{-1, 32'h80000000, 32'h7fffffff, 1'b0, 1'b1, sing},
			'{-1, 32'h00000000, 32'h00000000, 1'b0, 1'b1, sing},
			'{-1, 32'hffffffff, 32'h00000001, 1'b1, 1'b1, sing_l},
			'{0, 32'h00000000, 32'h00000000, 1'b0, 1'b0, sing},
			'{0, 32'h00010000, 32'h00000000, 1'b0, 1'b0, sing},
			'{0, 32'h00000000, 32'hffff0000, 1'b1, 1'b0, sing},
			'{0, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0, sing},
			'{0, 32'h80000000, 32'h80000000, 1'b1, 1'b0, sing},
			'{1, 32'h00000001, 32'hffffffff, 1'b0, 1'b0, sing},
			'{1, 32'h80000000, 32'h00000000, 1'b0, 1'b0, sing},
			'{1, 32'h00000000, 32'h00000000, 1'b1, 1'b0, sing},
			'{2, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0, sing},
			'{2, 32'h80000000, 32'h80000000, 1'b1, 1'b0, sing},
			'{3, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0, sing},
			'{3, 32'h00000001, 32'h80000000, 1'b1, 1'b0, sing},
			'{4, 32'h12345678, 32'h9abcdef0, 1'b1, 1'b0, sing},
			'{5, 32'h00018000, 32'hfffe8000, 1'b0, 1'b0, sing},
			'{5, 32'hffff8000, 32'h00008000, 1'b1, 1'b0, sing}
		};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CD_11;
		cfg_wdata <= '0;
		foreach (cd_reg[i]) cd_reg[i] = '0;
		ref_x = '0;
		ref_y = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = -1;
		foreach (rows[i]) begin
			if (rows[i].cfg_set != cur_set) begin
				s_tvalid <= 1'b0;
				load_config(rows[i].cfg_set);
				cur_set = rows[i].cfg_set;
			end
			typed_flag.push_back(rows[i].typed);
			if (rows[i].typed) typed_pix.push_back(rows[i].exp_pix);
			send_offset(rows[i].ra, rows[i].dec, rows[i].last);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			s_tvalid <= 1'b0;
			load_config(ph < 6 ? ph : 6);
			gap_max = (ph % 3 == 1) ? 0 : 9;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					ra = rand_word();
					dec = rand_word();
				end else begin
					// realistic offsets: within about +/-1000 arcsec
					ra = $signed(32'(int'($urandom_range(0, 32'h7d000000)) - 32'h3e800000)) >>> 4;
					dec = $signed(32'(int'($urandom_range(0, 32'h7d000000)) - 32'h3e800000)) >>> 4;
				end
				typed_flag.push_back(1'b0);
				send_offset(ra, dec, $urandom_range(0, 7) == 0);
			end
		end
		s_tvalid <= 1'b0;
		gap_max = 9;
		wait_drained();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
